>>> rtl/core/i2cm_pkg.sv
// types and constants shared by the i2c register access master
// no dependencies
`default_nettype none

package i2cm_pkg;

	localparam int unsigned HALF_W              = 16;
	localparam logic [15:0] HALF_PERIOD_RESET   = 16'd10;
	localparam int unsigned ACK_POLL_LIMIT_DEF  = 6;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_REQ  = 1'b1;

	// transfer plan steps
	localparam logic [2:0] STEP_DEV_WR  = 3'd0;
	localparam logic [2:0] STEP_REG_HI  = 3'd1;
	localparam logic [2:0] STEP_REG_LO  = 3'd2;
	localparam logic [2:0] STEP_DATA    = 3'd3;
	localparam logic [2:0] STEP_DEV_RD  = 3'd4;
	localparam logic [2:0] STEP_READ    = 3'd5;
	localparam logic [2:0] STEP_STOP    = 3'd6;
	localparam logic [2:0] STEP_FAIL    = 3'd7;

	typedef struct packed {
		logic        is_read;
		logic        wide_reg;
		logic [6:0]  dev_addr;
		logic [15:0] reg_addr;
		logic [7:0]  wr_data;
	} req_t;

	typedef struct packed {
		logic kind;
		req_t req;
		logic sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_low;
		logic       busy;
		logic       done;
		logic       status;
		logic [7:0] rd_data;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/i2cm_ifs.sv
// valid/ready channel interfaces for request/tick items and results
// depends on nothing
`default_nettype none

interface i2cm_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        is_read;
	logic        wide_reg;
	logic [6:0]  dev_addr;
	logic [15:0] reg_addr;
	logic [7:0]  wr_data;
	logic        sda_in;

	modport source (output valid, kind, is_read, wide_reg, dev_addr, reg_addr, wr_data, sda_in,
		input ready);
	modport sink (input valid, kind, is_read, wide_reg, dev_addr, reg_addr, wr_data, sda_in,
		output ready);
endinterface

interface i2cm_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_low;
	logic       busy_res;
	logic       done_res;
	logic       status;
	logic [7:0] rd_data;

	modport source (output valid, scl, sda_low, busy_res, done_res, status, rd_data,
		input ready);
	modport sink (input valid, scl, sda_low, busy_res, done_res, status, rd_data,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/i2cm_seq.sv
// transfer sequencer: phase, counters, shift byte and latched request
// depends on i2cm_pkg
`default_nettype none

module i2cm_seq #(
	parameter int unsigned ACK_POLL_LIMIT = i2cm_pkg::ACK_POLL_LIMIT_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   adv,
	input  wire i2cm_pkg::item_t  item,
	input  wire [15:0]            half_period,
	output i2cm_pkg::result_t     res
);
	import i2cm_pkg::*;

	localparam int unsigned POLL_W = $clog2(ACK_POLL_LIMIT + 1);

	typedef enum logic [4:0] {
		PH_IDLE, PH_STA, PH_STB, PH_STC, PH_WLO, PH_WHI, PH_ALO, PH_APOLL, PH_AHOLD,
		PH_RLO, PH_RHI, PH_NKA, PH_NKB, PH_NKC, PH_SPP, PH_SPA, PH_SPB
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [15:0]        tick_q, tick_n;
	logic [2:0]         bit_q, bit_n;
	logic [2:0]         step_q, step_n;
	logic [POLL_W-1:0]  poll_q, poll_n;
	logic [7:0]         shift_q, shift_n;
	req_t               lat_q, lat_n;
	logic [7:0]         read_q, read_n;
	logic               status_q, status_n;

	logic [15:0] hlen, plen, seg_len;
	logic [16:0] tc_inc;
	logic        do_begin, done;
	logic [2:0]  eff;
	logic        lvl_scl, lvl_sda, tx_bit;

	assign hlen   = (half_period == 16'd0) ? 16'd1 : half_period;
	assign plen   = (half_period[15:1] == 15'd0) ? 16'd1 : {1'b0, half_period[15:1]};
	assign tc_inc = {1'b0, tick_q} + 17'd1;
	assign tx_bit = shift_q[~bit_q];

	// line levels from the current state
	always_comb begin
		lvl_scl = 1'b1;
		lvl_sda = 1'b0;
		case (phase_q)
			PH_STA: lvl_scl = (step_q == STEP_DEV_WR);
			PH_STC: lvl_sda = 1'b1;
			PH_WLO: begin
				lvl_scl = 1'b0;
				lvl_sda = ~tx_bit;
			end
			PH_WHI: lvl_sda = ~tx_bit;
			PH_ALO, PH_RLO, PH_NKA, PH_NKB: lvl_scl = 1'b0;
			PH_SPP: begin
				lvl_scl = 1'b0;
				lvl_sda = 1'b1;
			end
			PH_SPA: lvl_sda = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		tick_n   = tick_q;
		bit_n    = bit_q;
		step_n   = step_q;
		poll_n   = poll_q;
		shift_n  = shift_q;
		lat_n    = lat_q;
		read_n   = read_q;
		status_n = status_q;
		do_begin = 1'b0;
		eff      = STEP_DEV_WR;
		done     = 1'b0;
		seg_len  = (phase_q == PH_SPP) ? 16'd1 : hlen;
		if (adv) begin
			if (item.kind == KIND_REQ) begin
				if (phase_q == PH_IDLE) begin
					lat_n   = item.req;
					step_n  = STEP_DEV_WR;
					bit_n   = 3'd0;
					poll_n  = '0;
					tick_n  = 16'd0;
					phase_n = PH_STA;
				end
			end else if (phase_q == PH_APOLL) begin
				if (tick_q == 16'd0 && !item.sda_in) begin
					phase_n = PH_AHOLD;
				end else if (tick_q == 16'd0 && poll_q >= POLL_W'(ACK_POLL_LIMIT)) begin
					step_n  = STEP_FAIL;
					phase_n = PH_SPP;
				end else begin
					if (tick_q == 16'd0)
						poll_n = poll_q + POLL_W'(1);
					tick_n = (tc_inc >= {1'b0, plen}) ? 16'd0 : tc_inc[15:0];
				end
			end else if (phase_q != PH_IDLE) begin
				if (phase_q == PH_RHI && tick_q == 16'd0)
					shift_n = {shift_q[6:0], item.sda_in};
				if (tc_inc >= {1'b0, seg_len}) begin
					tick_n = 16'd0;
					case (phase_q)
						PH_STA: phase_n = PH_STB;
						PH_STB: phase_n = PH_STC;
						PH_STC: begin
							do_begin = 1'b1;
							eff = (step_q == STEP_DEV_WR) ? STEP_DEV_WR : STEP_DEV_RD;
						end
						PH_WLO: phase_n = PH_WHI;
						PH_WHI: begin
							if (bit_q == 3'd7) begin
								phase_n = PH_ALO;
							end else begin
								bit_n   = bit_q + 3'd1;
								phase_n = PH_WLO;
							end
						end
						PH_ALO: begin
							poll_n  = '0;
							phase_n = PH_APOLL;
						end
						PH_AHOLD: begin
							do_begin = 1'b1;
							eff = (step_q == STEP_DEV_WR && !lat_q.wide_reg) ? STEP_REG_LO :
								step_q + 3'd1;
						end
						PH_RLO: phase_n = PH_RHI;
						PH_RHI: begin
							if (bit_q == 3'd7) begin
								phase_n = PH_NKA;
							end else begin
								bit_n   = bit_q + 3'd1;
								phase_n = PH_RLO;
							end
						end
						PH_NKA: phase_n = PH_NKB;
						PH_NKB: phase_n = PH_NKC;
						PH_NKC: begin
							read_n   = shift_q;
							do_begin = 1'b1;
							eff      = STEP_STOP;
						end
						PH_SPP: phase_n = PH_SPA;
						PH_SPA: phase_n = PH_SPB;
						PH_SPB: begin
							status_n = (step_q == STEP_FAIL);
							phase_n  = PH_IDLE;
							done     = 1'b1;
						end
						default: phase_n = PH_IDLE;
					endcase
				end else begin
					tick_n = tc_inc[15:0];
				end
			end
		end
		// start of the next step of the transfer plan
		if (do_begin) begin
			step_n = eff;
			bit_n  = 3'd0;
			tick_n = 16'd0;
			poll_n = '0;
			case (eff)
				STEP_DEV_WR: begin
					shift_n = {lat_q.dev_addr, 1'b0};
					phase_n = PH_WLO;
				end
				STEP_REG_HI: begin
					shift_n = lat_q.reg_addr[15:8];
					phase_n = PH_WLO;
				end
				STEP_REG_LO: begin
					shift_n = lat_q.reg_addr[7:0];
					phase_n = PH_WLO;
				end
				STEP_DATA: begin
					if (lat_q.is_read) begin
						phase_n = PH_STA;
					end else begin
						shift_n = lat_q.wr_data;
						phase_n = PH_WLO;
					end
				end
				STEP_DEV_RD: begin
					if (lat_q.is_read) begin
						shift_n = {lat_q.dev_addr, 1'b1};
						phase_n = PH_WLO;
					end else begin
						phase_n = PH_SPP;
					end
				end
				STEP_READ: begin
					if (lat_q.is_read) begin
						shift_n = 8'd0;
						phase_n = PH_RLO;
					end else begin
						phase_n = PH_SPP;
					end
				end
				default: phase_n = PH_SPP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= 16'd0;
			bit_q    <= 3'd0;
			step_q   <= STEP_DEV_WR;
			poll_q   <= '0;
			shift_q  <= 8'd0;
			lat_q    <= '0;
			read_q   <= 8'd0;
			status_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			tick_q   <= tick_n;
			bit_q    <= bit_n;
			step_q   <= step_n;
			poll_q   <= poll_n;
			shift_q  <= shift_n;
			lat_q    <= lat_n;
			read_q   <= read_n;
			status_q <= status_n;
		end
	end

	assign res.scl     = lvl_scl;
	assign res.sda_low = lvl_sda;
	assign res.busy    = (phase_n != PH_IDLE);
	assign res.done    = done;
	assign res.status  = status_n;
	assign res.rd_data = read_n;

	a_poll_bound: assert property (@(posedge clk) disable iff (!arst_n)
		poll_q <= POLL_W'(ACK_POLL_LIMIT))
		else $error("ack poll count past limit");

	a_idle_levels: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> lvl_scl && !lvl_sda)
		else $error("lines not released while idle");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |=> phase_q == PH_IDLE && tick_q == 16'd0)
		else $error("sequencer not idle after done");

	a_done_from_stop: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |-> phase_q == PH_SPB && !res.busy)
		else $error("done outside the stop segment");

	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done && step_q == STEP_FAIL |=> status_q)
		else $error("failed transfer reported as success");

endmodule

`default_nettype wire

>>> rtl/core/i2c_master_register_access_unit.sv
// i2c register access master: input register, sequencer, result register
// one result per tick or request item, one item per clock unless rsp stalls
// arst_n clears the sequencer to idle, both stages to empty and half_period to 10
// depends on i2cm_pkg, i2cm_ifs and i2cm_seq
`default_nettype none

module i2c_master_register_access_unit #(
	parameter int unsigned ACK_POLL_LIMIT = i2cm_pkg::ACK_POLL_LIMIT_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	i2cm_req_if.sink     req,
	i2cm_rsp_if.source   rsp,
	input  wire          cfg_wr_en,
	input  wire [15:0]   cfg_wr_data
);
	import i2cm_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res_c;
	logic        adv;
	logic [15:0] half_period_q;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			half_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.kind          <= req.kind;
			item_s1.req.is_read   <= req.is_read;
			item_s1.req.wide_reg  <= req.wide_reg;
			item_s1.req.dev_addr  <= req.dev_addr;
			item_s1.req.reg_addr  <= req.reg_addr;
			item_s1.req.wr_data   <= req.wr_data;
			item_s1.sda_in        <= req.sda_in;
		end
	end

	i2cm_seq #(
		.ACK_POLL_LIMIT (ACK_POLL_LIMIT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item        (item_s1),
		.half_period (half_period_q),
		.res         (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_c;
	end

	assign rsp.valid    = valid_s2;
	assign rsp.scl      = res_s2.scl;
	assign rsp.sda_low  = res_s2.sda_low;
	assign rsp.busy_res = res_s2.busy;
	assign rsp.done_res = res_s2.done;
	assign rsp.status   = res_s2.status;
	assign rsp.rd_data  = res_s2.rd_data;

endmodule

`default_nettype wire

>>> test/tb_i2c_master_register_access_unit.sv
// testbench for the i2c register access master: drives request and tick items,
// predicts scl/sda levels, busy, done, status and read byte per item and checks them
// depends on i2cm_pkg, i2cm_ifs and i2c_master_register_access_unit

module tb_i2c_master_register_access_unit;

	import i2cm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_STA, S_STB, S_STC, S_WLO, S_WHI, S_ALO, S_APOLL, S_AHOLD,
		S_RLO, S_RHI, S_NKA, S_NKB, S_NKC, S_SPP, S_SPA, S_SPB
	} seq_phase_t;

	typedef struct {
		seq_phase_t  ph;
		int unsigned cnt;
		logic [3:0]  bit_i;
		logic [2:0]  step;
		logic [2:0]  polls;
		logic [7:0]  shreg;
		req_t        lat;
		logic [7:0]  rbyte;
		logic        stat;
		logic [15:0] half;
	} i2c_seq_t;

	localparam int NO_FAIL   = 8;
	localparam int RD_RANDOM = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	i2cm_req_if req_ch();
	i2cm_rsp_if rsp_ch();

	i2c_master_register_access_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	i2c_seq_t    model_st;
	i2c_seq_t    plan_st;
	item_t       tick_req_q[$];
	result_t     levels_q[$];
	int unsigned pushed_cnt;
	int unsigned accepted_cnt;
	int unsigned phase_items;
	int unsigned mismatch_cnt;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        fire_seen;

	function automatic int unsigned half_ticks(input logic [15:0] h);
		return (h == 16'd0) ? 1 : 32'(h);
	endfunction

	function automatic int unsigned poll_ticks(input logic [15:0] h);
		return (h < 16'd2) ? 1 : 32'(h >> 1);
	endfunction

	function automatic void load_byte(inout i2c_seq_t s, input logic [7:0] b);
		s.shreg = b;
		s.ph = S_WLO;
	endfunction

	function automatic void begin_step(inout i2c_seq_t s, input logic [2:0] eff);
		s.step = eff;
		s.bit_i = '0;
		s.cnt = 0;
		s.polls = '0;
		if (eff == STEP_DEV_WR) begin
			load_byte(s, {s.lat.dev_addr, 1'b0});
		end else if (eff == STEP_REG_HI) begin
			load_byte(s, s.lat.reg_addr[15:8]);
		end else if (eff == STEP_REG_LO) begin
			load_byte(s, s.lat.reg_addr[7:0]);
		end else if (!s.lat.is_read) begin
			if (eff == STEP_DATA) load_byte(s, s.lat.wr_data);
			else s.ph = S_SPP;
		end else if (eff == STEP_DATA) begin
			// repeated start before the read address
			s.ph = S_STA;
		end else if (eff == STEP_DEV_RD) begin
			load_byte(s, {s.lat.dev_addr, 1'b1});
		end else if (eff == STEP_READ) begin
			s.shreg = '0;
			s.ph = S_RLO;
		end else begin
			s.ph = S_SPP;
		end
	endfunction

	function automatic logic finish_seg(inout i2c_seq_t s);
		s.cnt = 0;
		case (s.ph)
			S_STA: s.ph = S_STB;
			S_STB: s.ph = S_STC;
			S_STC: begin_step(s, (s.step == STEP_DEV_WR) ? STEP_DEV_WR : STEP_DEV_RD);
			S_WLO: s.ph = S_WHI;
			S_WHI: begin
				if (s.bit_i >= 4'd7) begin
					s.ph = S_ALO;
				end else begin
					s.bit_i = s.bit_i + 4'd1;
					s.ph = S_WLO;
				end
			end
			S_ALO: begin
				s.polls = '0;
				s.ph = S_APOLL;
			end
			S_AHOLD: begin
				if (s.step == STEP_DEV_WR && !s.lat.wide_reg) begin_step(s, STEP_REG_LO);
				else begin_step(s, s.step + 3'd1);
			end
			S_RLO: s.ph = S_RHI;
			S_RHI: begin
				if (s.bit_i >= 4'd7) begin
					s.ph = S_NKA;
				end else begin
					s.bit_i = s.bit_i + 4'd1;
					s.ph = S_RLO;
				end
			end
			S_NKA: s.ph = S_NKB;
			S_NKB: s.ph = S_NKC;
			S_NKC: begin
				s.rbyte = s.shreg;
				begin_step(s, STEP_STOP);
			end
			S_SPP: s.ph = S_SPA;
			S_SPA: s.ph = S_SPB;
			S_SPB: begin
				s.stat = (s.step == STEP_FAIL);
				s.ph = S_IDLE;
				return 1'b1;
			end
			default: s.ph = S_IDLE;
		endcase
		return 1'b0;
	endfunction

	function automatic logic tick_seq(inout i2c_seq_t s, input logic sda);
		int unsigned len;
		if (s.ph == S_IDLE) return 1'b0;
		if (s.ph == S_APOLL) begin
			if (s.cnt == 0) begin
				if (!sda) begin
					s.ph = S_AHOLD;
					return 1'b0;
				end
				if (s.polls >= ACK_POLL_LIMIT_DEF) begin
					s.step = STEP_FAIL;
					s.ph = S_SPP;
					return 1'b0;
				end
				s.polls = s.polls + 3'd1;
			end
			s.cnt = s.cnt + 1;
			if (s.cnt >= poll_ticks(s.half)) s.cnt = 0;
			return 1'b0;
		end
		if (s.ph == S_RHI && s.cnt == 0) s.shreg = {s.shreg[6:0], sda};
		len = (s.ph == S_SPP) ? 1 : half_ticks(s.half);
		s.cnt = s.cnt + 1;
		if (s.cnt >= len) return finish_seg(s);
		return 1'b0;
	endfunction

	// line levels come from the state before the item is applied
	function automatic result_t i2c_predict_step(inout i2c_seq_t s, input item_t it);
		result_t r;
		logic    txb;
		r = '0;
		txb = s.shreg[3'd7 - s.bit_i[2:0]];
		r.scl = 1'b1;
		r.sda_low = 1'b0;
		case (s.ph)
			S_STA: r.scl = (s.step == STEP_DEV_WR);
			S_STC, S_SPA: r.sda_low = 1'b1;
			S_WLO: begin
				r.scl = 1'b0;
				r.sda_low = !txb;
			end
			S_WHI: r.sda_low = !txb;
			S_ALO, S_RLO, S_NKA, S_NKB: r.scl = 1'b0;
			S_SPP: begin
				r.scl = 1'b0;
				r.sda_low = 1'b1;
			end
			default: ;
		endcase
		if (it.kind == KIND_REQ) begin
			if (s.ph == S_IDLE) begin
				s.lat = it.req;
				s.step = STEP_DEV_WR;
				s.bit_i = '0;
				s.polls = '0;
				s.cnt = 0;
				s.ph = S_STA;
			end
		end else begin
			r.done = tick_seq(s, it.sda_in);
		end
		r.busy = (s.ph != S_IDLE);
		r.status = s.stat;
		r.rd_data = s.rbyte;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		if (mismatch_cnt < 40)
			$display("mismatch %0s: got %h, expected %h at %0t", what, got, want, $time);
		mismatch_cnt++;
	endtask

	function automatic item_t rand_item(input logic k);
		item_t it;
		it.kind = k;
		it.req.is_read = 1'($urandom_range(1));
		it.req.wide_reg = 1'($urandom_range(1));
		it.req.dev_addr = 7'($urandom_range(127));
		it.req.reg_addr = 16'($urandom_range(65535));
		it.req.wr_data = 8'($urandom_range(255));
		it.sda_in = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic push_item(input item_t it);
		void'(i2c_predict_step(plan_st, it));
		tick_req_q.push_back(it);
		pushed_cnt++;
		phase_items++;
	endtask

	task automatic push_idle_ticks(input int n);
		repeat (n) push_item(rand_item(KIND_TICK));
	endtask

	task automatic start_xfer(input logic rd, input logic wide, input logic [6:0] dev,
		input logic [15:0] ra, input logic [7:0] wd);
		item_t it;
		it = rand_item(KIND_REQ);
		it.req.is_read = rd;
		it.req.wide_reg = wide;
		it.req.dev_addr = dev;
		it.req.reg_addr = ra;
		it.req.wr_data = wd;
		push_item(it);
	endtask

	// ticks until the planned transfer ends; acks and read bits steered from sda_in
	task automatic run_ticks(input int fail_at, input int ack_pct, input int rd_fill);
		item_t it;
		while (plan_st.ph != S_IDLE) begin
			it = rand_item(KIND_TICK);
			if (plan_st.ph == S_APOLL)
				it.sda_in = (int'(plan_st.step) == fail_at) || ($urandom_range(99) >= ack_pct);
			else if (plan_st.ph == S_RHI && rd_fill != RD_RANDOM)
				it.sda_in = rd_fill[0];
			else if ($urandom_range(199) == 0)
				it.kind = KIND_REQ;
			push_item(it);
		end
	endtask

	task automatic random_xfer();
		int fail_at;
		fail_at = ($urandom_range(5) == 0) ? int'($urandom_range(5)) : NO_FAIL;
		push_idle_ticks(int'($urandom_range(3)));
		start_xfer(1'($urandom_range(1)), 1'($urandom_range(1)), 7'($urandom_range(127)),
			16'($urandom_range(65535)), 8'($urandom_range(255)));
		run_ticks(fail_at, int'($urandom_range(40, 90)), RD_RANDOM);
	endtask

	task automatic drain();
		while (accepted_cnt != pushed_cnt || levels_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_half(input logic [15:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		model_st.half = v;
		plan_st.half = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sender and receiver side, changed on the falling edge
	always @(negedge clk) begin : drive_blk
		item_t nxt;
		if (!req_ch.valid || fire_seen) begin
			if (tick_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = tick_req_q.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind <= nxt.kind;
				req_ch.is_read <= nxt.req.is_read;
				req_ch.wide_reg <= nxt.req.wide_reg;
				req_ch.dev_addr <= nxt.req.dev_addr;
				req_ch.reg_addr <= nxt.req.reg_addr;
				req_ch.wr_data <= nxt.req.wr_data;
				req_ch.sda_in <= nxt.sda_in;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// accepted items go through the predictor, result transfers are checked
	always @(posedge clk) begin : mon_blk
		item_t   acc;
		result_t want;
		fire_seen <= (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
		if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
			acc.kind = req_ch.kind;
			acc.req.is_read = req_ch.is_read;
			acc.req.wide_reg = req_ch.wide_reg;
			acc.req.dev_addr = req_ch.dev_addr;
			acc.req.reg_addr = req_ch.reg_addr;
			acc.req.wr_data = req_ch.wr_data;
			acc.sda_in = req_ch.sda_in;
			levels_q.push_back(i2c_predict_step(model_st, acc));
			accepted_cnt++;
		end
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (levels_q.size() == 0) begin
				report_mismatch("unexpected transfer", 16'd0, 16'd0);
			end else begin
				want = levels_q.pop_front();
				if (rsp_ch.scl !== want.scl)
					report_mismatch("scl", 16'(rsp_ch.scl), 16'(want.scl));
				if (rsp_ch.sda_low !== want.sda_low)
					report_mismatch("sda_low", 16'(rsp_ch.sda_low), 16'(want.sda_low));
				if (rsp_ch.busy_res !== want.busy)
					report_mismatch("busy_res", 16'(rsp_ch.busy_res), 16'(want.busy));
				if (rsp_ch.done_res !== want.done)
					report_mismatch("done_res", 16'(rsp_ch.done_res), 16'(want.done));
				if (rsp_ch.status !== want.status)
					report_mismatch("status", 16'(rsp_ch.status), 16'(want.status));
				if (rsp_ch.rd_data !== want.rd_data)
					report_mismatch("rd_data", 16'(rsp_ch.rd_data), 16'(want.rd_data));
			end
		end
	end

	initial begin : stim
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_TICK;
		req_ch.is_read = 1'b0;
		req_ch.wide_reg = 1'b0;
		req_ch.dev_addr = '0;
		req_ch.reg_addr = '0;
		req_ch.wr_data = '0;
		req_ch.sda_in = 1'b0;
		rsp_ch.ready = 1'b0;
		fire_seen = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pushed_cnt = 0;
		accepted_cnt = 0;
		phase_items = 0;
		mismatch_cnt = 0;
		model_st.ph = S_IDLE;
		model_st.cnt = 0;
		model_st.bit_i = '0;
		model_st.step = STEP_DEV_WR;
		model_st.polls = '0;
		model_st.shreg = '0;
		model_st.lat = '0;
		model_st.rbyte = '0;
		model_st.stat = 1'b0;
		model_st.half = HALF_PERIOD_RESET;
		plan_st = model_st;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle ticks, then a narrow write at the reset half period that gets no ack
		push_idle_ticks(3);
		start_xfer(1'b0, 1'b0, 7'h7f, 16'h00a5, 8'h5a);
		run_ticks(int'(STEP_DEV_WR), 70, RD_RANDOM);
		drain();
		set_half(16'd1);
		// wide write with a request landing while busy
		start_xfer(1'b0, 1'b1, 7'h00, 16'hffff, 8'hff);
		push_idle_ticks(5);
		push_item(rand_item(KIND_REQ));
		run_ticks(NO_FAIL, 50, RD_RANDOM);
		start_xfer(1'b1, 1'b0, 7'h55, 16'h0000, 8'h00);
		run_ticks(NO_FAIL, 80, 0);
		start_xfer(1'b1, 1'b1, 7'h2a, 16'h8001, 8'h00);
		run_ticks(NO_FAIL, 80, 1);
		// no ack on the address byte, then none on the read address
		start_xfer(1'b0, 1'b0, 7'h11, 16'h1234, 8'h99);
		run_ticks(int'(STEP_DEV_WR), 0, RD_RANDOM);
		start_xfer(1'b1, 1'b1, 7'h6c, 16'h4321, 8'h00);
		run_ticks(int'(STEP_DEV_RD), 60, RD_RANDOM);
		drain();
		set_half(16'd0);
		start_xfer(1'b1, 1'b1, 7'h3c, 16'hc3a5, 8'h00);
		run_ticks(NO_FAIL, 50, RD_RANDOM);
		drain();
		// longest half period, cut short mid start condition
		set_half(16'hffff);
		start_xfer(1'b0, 1'b0, 7'h40, 16'h0081, 8'h7e);
		push_idle_ticks(40);
		drain();
		set_half(16'd1);
		run_ticks(NO_FAIL, 60, RD_RANDOM);
		drain();

		for (int m = 0; m < 4; m++) begin
			send_idle_pct = (m == 1) ? 87 : (m == 3) ? 18 : 0;
			recv_stall_pct = (m == 2) ? 87 : (m == 3) ? 18 : 0;
			set_half((m == 3) ? 16'($urandom_range(1, 3)) : (m == 1) ? 16'd2 : 16'd1);
			phase_items = 0;
			while (phase_items < 40) random_xfer();
			drain();
		end

		repeat (8) @(posedge clk);
		if (levels_q.size() != 0)
			report_mismatch("results missing", 16'(levels_q.size()), 16'd0);
		if (mismatch_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin : watchdog
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_ifs.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_register_access_unit.sv
test/tb_i2c_master_register_access_unit.sv
